// ===== sv/wsp_pkg.sv =====
`timescale 1ns / 1ps

package wsp_pkg;

  // field and state widths
  localparam int unsigned SpeedW   = 15;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned SumW     = 32;
  localparam int unsigned IntW     = 48;
  localparam int unsigned CycW     = 24;
  localparam int unsigned TgtW     = 24;
  localparam int unsigned GainW    = 32;
  localparam int unsigned ChunkW   = 16;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = GainW + MulBW;
  localparam int unsigned FracW    = 14;
  localparam int unsigned TermMagW = 21;
  localparam int unsigned TermW    = TermMagW + 1;
  localparam int unsigned CorrW    = TermW + 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MOVE_KIND   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_START_SPEED = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TOP_SPEED   = 3'd5;

  // move kinds and commands
  localparam logic [1:0] KIND_STRAIGHT = 2'd0;
  localparam logic [1:0] KIND_SPIN_POS = 2'd1;
  localparam logic [1:0] KIND_SPIN_NEG = 2'd2;
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register reset values
  localparam logic [GainW-1:0]  PROP_GAIN_RST  = 32'd429;
  localparam logic [GainW-1:0]  INTEG_GAIN_RST = 32'd2147484;
  localparam logic [SpeedW-1:0] START_RST      = 15'd3277;
  localparam logic [SpeedW-1:0] TOP_RST        = 15'd13107;

  // ramp constants, speeds Q1.14
  localparam logic [SpeedW-1:0] STEP_UP     = 15'd164;
  localparam logic [SpeedW-1:0] STEP_DOWN   = 15'd328;
  localparam logic [SpeedW-1:0] RAMP_FLOOR  = 15'd2458;
  localparam logic [GainW-1:0]  DECEL_SCALE = 32'd5000;

  // pi term magnitude limit and the integer part where it is reached
  localparam logic [TermMagW-1:0] TERM_LIMIT = 21'd1048576;
  localparam int unsigned TermHi = 1 << (TermMagW - 1 - FracW);

  typedef struct packed {
    logic                     command;
    logic signed [DeltaW-1:0] right_delta;
    logic signed [DeltaW-1:0] left_delta;
  } wsp_in_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    logic                     move_done;
  } wsp_out_t;

  // accumulator control for the chunked gain product
  typedef struct packed {
    logic clr;
    logic load;
    logic frac_en;
  } gacc_ctrl_t;

endpackage

// ===== sv/wsp_mul.sv =====
`timescale 1ns / 1ps

module wsp_mul import wsp_pkg::*; (
  input  logic             clk_i,
  input  logic [GainW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/wsp_gacc.sv =====
`timescale 1ns / 1ps

module wsp_gacc import wsp_pkg::*; (
  input  logic                clk_i,
  input  gacc_ctrl_t          ctrl_i,
  input  logic [ProdW-1:0]    prod_i,
  output logic [TermMagW-1:0] term_mag_o
);

  logic [ProdW-1:0] acc_q;
  logic [FracW-1:0] frac_q;
  logic [ProdW-1:0] sum;
  logic             sat;

  // each partial product lands 16 bits above the previous one
  assign sum = prod_i + (acc_q >> ChunkW);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.load) begin
      acc_q <= sum;
    end
    if (ctrl_i.frac_en) begin
      frac_q <= sum[ChunkW-1 -: FracW];
    end
  end

  // sum holds the product above bit 32, frac_q bits 31..18
  assign sat = (sum > ProdW'(TermHi)) || ((sum == ProdW'(TermHi)) && (frac_q != '0));
  assign term_mag_o = sat ? TERM_LIMIT : {sum[TermMagW-FracW-1:0], frac_q};

endmodule

// ===== sv/wheel_sync_pi_ramp_controller.sv =====
`timescale 1ns / 1ps

// channel   signals                                  role
// in        in_valid_i, in_ready_o, in_data_i        start command or encoder sample
// out       out_valid_o, out_ready_i, out_data_o     left/right drive and move_done
// cfg       cfg_we_i, cfg_index_i, cfg_wdata_i       register write, no wait
//
// sample: sums, integral, two pi terms on the one 32x17 multiplier, result step (no pi
//   terms if it ends the move); start command or sample while idle: result step only
// one item at a time, the next transfer in the cycle after the result step; a result
//   waits in the output register while the next item runs, the result step stalls if full
// reset clears config, move state and sequencer, not the working or output data
//   registers; no clearing pass is needed.
module wheel_sync_pi_ramp_controller import wsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wsp_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wsp_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUMS  = 3'd1;
  localparam logic [2:0] ST_INTEG = 3'd2;
  localparam logic [2:0] ST_GAIN  = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;

  localparam logic [1:0] RK_START = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_RUN   = 2'd2;

  localparam logic [1:0] CHUNK0 = 2'd0;
  localparam logic [1:0] CHUNK1 = 2'd1;
  localparam logic [1:0] CHUNK2 = 2'd2;
  localparam logic [1:0] K_LAST = 2'd3;

  localparam logic [CycW-1:0] CYCLE_ONE = 24'd1;
  localparam logic [CycW-1:0] CYCLE_MAX = '1;

  function automatic logic signed [SumW-1:0] sat_sum(logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v[SumW] != v[SumW-1]) begin
      r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IntW-1:0] sat_int(logic signed [IntW:0] v);
    logic signed [IntW-1:0] r;
    if (v[IntW] != v[IntW-1]) begin
      r = v[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
    end else begin
      r = v[IntW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [1:0]        kind_q;
  logic [TgtW-1:0]   target_q;
  logic [GainW-1:0]  pgain_q;
  logic [GainW-1:0]  igain_q;
  logic [SpeedW-1:0] start_q;
  logic [SpeedW-1:0] top_q;

  // move state
  logic signed [SumW-1:0] rsum_q;
  logic signed [SumW-1:0] lsum_q;
  logic signed [IntW-1:0] integ_q;
  logic [CycW-1:0]        cycle_q;
  logic [SpeedW-1:0]      ramp_q;
  logic                   moving_q;

  // sequencer
  logic [2:0] state_q;
  logic       j_q;
  logic [1:0] k_q;
  logic [1:0] rk_q;
  logic       out_valid_q;

  // per-item working registers
  logic signed [DeltaW-1:0] rd_q;
  logic signed [DeltaW-1:0] ld_q;
  logic [MulBW-1:0]         pmag_q;
  logic                     pneg_q;
  logic [IntW-1:0]          imag_q;
  logic                     ineg_q;
  logic                     dneg_q;
  logic signed [CorrW-1:0]  corr_q;
  wsp_out_t                 out_data_q;

  logic spin;
  logic sneg;
  logic in_xfer;
  logic res_fire;

  assign spin     = kind_q inside {KIND_SPIN_POS, KIND_SPIN_NEG};
  assign sneg     = (kind_q == KIND_SPIN_NEG);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign res_fire = (state_q == ST_RES) && (!out_valid_q || out_ready_i);

  // ---------------- sums step
  logic signed [DeltaW:0]   rd_x, ld_x, r_w, l_w;
  logic signed [DeltaW+1:0] errp;
  logic [DeltaW+1:0]        errp_abs;
  logic signed [SumW-1:0]   rsum_new, lsum_new;
  logic [DeltaW-1:0]        rdmag;

  assign rd_x = {rd_q[DeltaW-1], rd_q};
  assign ld_x = {ld_q[DeltaW-1], ld_q};
  // spin counts: right gets -s, left gets s
  assign r_w  = (spin && !sneg) ? -rd_x : rd_x;
  assign l_w  = (spin && sneg) ? -ld_x : ld_x;
  assign errp = {r_w[DeltaW], r_w} - {l_w[DeltaW], l_w};
  assign errp_abs = errp[DeltaW+1] ? (DeltaW+2)'(0) - errp : errp;
  assign rdmag = rd_q[DeltaW-1] ? DeltaW'(-rd_q) : rd_q;

  assign rsum_new = sat_sum({rsum_q[SumW-1], rsum_q} + {{(SumW-DeltaW){r_w[DeltaW]}}, r_w});
  assign lsum_new = sat_sum({lsum_q[SumW-1], lsum_q} + {{(SumW-DeltaW){l_w[DeltaW]}}, l_w});

  // ---------------- multiplier
  logic [GainW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [IntW-1:0]  mag_sel;
  logic [ChunkW-1:0] chunk;
  logic [SpeedW-1:0] dmag;

  assign mag_sel = j_q ? IntW'(pmag_q) : imag_q;

  always_comb begin
    case (k_q)
      CHUNK0:  chunk = mag_sel[ChunkW-1:0];
      CHUNK1:  chunk = mag_sel[2*ChunkW-1:ChunkW];
      CHUNK2:  chunk = mag_sel[3*ChunkW-1:2*ChunkW];
      default: chunk = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_SUMS: begin
        mul_a = GainW'(cycle_q);
        mul_b = MulBW'(rdmag);
      end
      ST_INTEG: begin
        mul_a = DECEL_SCALE;
        mul_b = MulBW'(dmag);
      end
      ST_GAIN: begin
        mul_a = j_q ? pgain_q : igain_q;
        mul_b = MulBW'(chunk);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wsp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------- integral step
  localparam int unsigned CycProdW = CycW + DeltaW;
  logic signed [CycProdW:0] cprod;
  logic signed [IntW-1:0]   integ_str, integ_new;
  logic signed [SumW:0]     rl_diff;
  logic [IntW-1:0]          integ_abs;
  logic signed [SumW:0]     tgt_x;
  logic                     rgt, lgt, done_w;
  logic signed [SumW+1:0]   three_l;
  logic [SpeedW:0]          ramp_inc;
  logic [SpeedW-1:0]        ramp_up_val, ramp_new;
  logic signed [SpeedW:0]   ddiff;

  assign cprod = rd_q[DeltaW-1] ? -$signed({1'b0, prod[CycProdW-1:0]})
                                :  $signed({1'b0, prod[CycProdW-1:0]});
  assign integ_str = {{(IntW-CycProdW-1){cprod[CycProdW]}}, cprod}
                   - {{(IntW-SumW){lsum_q[SumW-1]}}, lsum_q};
  assign rl_diff = {rsum_q[SumW-1], rsum_q} - {lsum_q[SumW-1], lsum_q};
  assign integ_new = spin ? sat_int({integ_q[IntW-1], integ_q}
                                    + {{(IntW-SumW){rl_diff[SumW]}}, rl_diff})
                          : integ_str;
  assign integ_abs = integ_new[IntW-1] ? IntW'(0) - integ_new : integ_new;

  assign tgt_x  = $signed({{(SumW+1-TgtW){1'b0}}, target_q});
  assign rgt    = $signed({rsum_q[SumW-1], rsum_q}) > tgt_x;
  assign lgt    = $signed({lsum_q[SumW-1], lsum_q}) > tgt_x;
  assign done_w = spin ? (rgt || lgt) : rgt;

  assign three_l  = {{2{lsum_q[SumW-1]}}, lsum_q}
                  + {lsum_q[SumW-1], lsum_q, 1'b0};
  assign ramp_inc = {1'b0, ramp_q} + {1'b0, STEP_UP};
  assign ramp_up_val = ramp_inc[SpeedW] ? '1 : ramp_inc[SpeedW-1:0];
  assign ramp_new = (!spin && (three_l <= $signed({tgt_x[SumW], tgt_x})) && (ramp_q < top_q))
                  ? ramp_up_val : ramp_q;
  assign ddiff = {1'b0, ramp_new} - {1'b0, start_q};
  assign dmag  = ddiff[SpeedW] ? SpeedW'(-ddiff) : ddiff[SpeedW-1:0];

  // ---------------- deceleration check, product of the integral step
  localparam int unsigned DecW = SumW + 1 + FracW;
  logic signed [SumW:0]   lt_diff;
  logic signed [IntW-1:0] dterm, dsum;
  logic                   decel;

  assign lt_diff = {lsum_q[SumW-1], lsum_q} - tgt_x;
  assign dterm   = dneg_q ? -$signed({1'b0, prod[IntW-2:0]}) : $signed({1'b0, prod[IntW-2:0]});
  assign dsum    = {{(IntW-DecW){lt_diff[SumW]}}, lt_diff, {FracW{1'b0}}} + dterm;
  assign decel   = !dsum[IntW-1] && (dsum != '0) && (ramp_q > RAMP_FLOOR);

  // ---------------- pi terms
  gacc_ctrl_t             gctrl;
  logic [TermMagW-1:0]    term_mag;
  logic signed [TermW-1:0] term;
  logic                   tneg;

  always_comb begin
    gctrl = '0;
    if (state_q == ST_GAIN) begin
      gctrl.clr     = (k_q == CHUNK0);
      gctrl.load    = (k_q == CHUNK1) || (k_q == CHUNK2);
      gctrl.frac_en = (k_q == CHUNK2);
    end
  end

  wsp_gacc u_gacc (
    .clk_i      (clk_i),
    .ctrl_i     (gctrl),
    .prod_i     (prod),
    .term_mag_o (term_mag)
  );

  assign tneg = j_q ? pneg_q : ineg_q;
  assign term = tneg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

  // ---------------- result
  localparam int unsigned BaseW = CorrW + 1;
  logic signed [BaseW-1:0]  base, lpre;
  logic signed [SpeedW+1:0] rpre;
  logic signed [DriveW-1:0] lclip;
  localparam logic signed [BaseW-1:0] DRV_MAX = BaseW'(32767);
  localparam logic signed [BaseW-1:0] DRV_MIN = -BaseW'(32768);

  assign base = $signed({{(BaseW-SpeedW){1'b0}}, ramp_q})
              + ((rk_q == RK_RUN) ? {corr_q[CorrW-1], corr_q} : BaseW'(0));
  assign lpre = (spin && sneg) ? -base : base;
  assign rpre = (spin && !sneg) ? -$signed({2'b0, ramp_q}) : $signed({2'b0, ramp_q});
  assign lclip = (lpre > DRV_MAX) ? DriveW'(DRV_MAX)
               : (lpre < DRV_MIN) ? DriveW'(DRV_MIN) : lpre[DriveW-1:0];

  // ---------------- control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_STRAIGHT;
      target_q    <= '0;
      pgain_q     <= PROP_GAIN_RST;
      igain_q     <= INTEG_GAIN_RST;
      start_q     <= START_RST;
      top_q       <= TOP_RST;
      rsum_q      <= '0;
      lsum_q      <= '0;
      integ_q     <= '0;
      cycle_q     <= CYCLE_ONE;
      ramp_q      <= START_RST;
      moving_q    <= 1'b0;
      state_q     <= ST_IDLE;
      j_q         <= 1'b0;
      k_q         <= CHUNK0;
      rk_q        <= RK_DONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MOVE_KIND:   kind_q   <= cfg_wdata_i[1:0];
          REG_TARGET:      target_q <= cfg_wdata_i[TgtW-1:0];
          REG_PROP_GAIN:   pgain_q  <= cfg_wdata_i[GainW-1:0];
          REG_INTEG_GAIN:  igain_q  <= cfg_wdata_i[GainW-1:0];
          REG_START_SPEED: start_q  <= cfg_wdata_i[SpeedW-1:0];
          REG_TOP_SPEED:   top_q    <= cfg_wdata_i[SpeedW-1:0];
          default: ;
        endcase
      end

      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data_i.command == CMD_START) begin
              rsum_q   <= '0;
              lsum_q   <= '0;
              integ_q  <= '0;
              cycle_q  <= CYCLE_ONE;
              ramp_q   <= start_q;
              moving_q <= 1'b1;
              rk_q     <= RK_START;
              state_q  <= ST_RES;
            end else if (!moving_q) begin
              rk_q    <= RK_DONE;
              state_q <= ST_RES;
            end else begin
              state_q <= ST_SUMS;
            end
          end
        end
        ST_SUMS: begin
          rsum_q  <= rsum_new;
          lsum_q  <= lsum_new;
          if (cycle_q != CYCLE_MAX) begin
            cycle_q <= cycle_q + CYCLE_ONE;
          end
          state_q <= ST_INTEG;
        end
        ST_INTEG: begin
          integ_q <= integ_new;
          if (done_w) begin
            moving_q <= 1'b0;
            rk_q     <= RK_DONE;
            state_q  <= ST_RES;
          end else begin
            ramp_q  <= ramp_new;
            j_q     <= 1'b0;
            k_q     <= CHUNK0;
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          // the decel product arrives while the first chunk is issued
          if (!j_q && (k_q == CHUNK0) && !spin && decel) begin
            ramp_q <= ramp_q - STEP_DOWN;
          end
          if (k_q == K_LAST) begin
            k_q <= CHUNK0;
            if (!j_q) begin
              j_q <= 1'b1;
            end else begin
              rk_q    <= RK_RUN;
              state_q <= ST_RES;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_RES: begin
          if (res_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------- working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= in_data_i.right_delta;
      ld_q <= in_data_i.left_delta;
    end
    if (state_q == ST_SUMS) begin
      pmag_q <= errp_abs[MulBW-1:0];
      pneg_q <= errp[DeltaW+1];
    end
    if (state_q == ST_INTEG) begin
      imag_q <= integ_abs;
      ineg_q <= integ_new[IntW-1];
      dneg_q <= ddiff[SpeedW];
    end
    if ((state_q == ST_GAIN) && (k_q == K_LAST)) begin
      corr_q <= j_q ? corr_q + {term[TermW-1], term} : {term[TermW-1], term};
    end
    if (res_fire) begin
      if (rk_q == RK_DONE) begin
        out_data_q.left_drive  <= '0;
        out_data_q.right_drive <= '0;
        out_data_q.move_done   <= 1'b1;
      end else begin
        out_data_q.left_drive  <= lclip;
        out_data_q.right_drive <= rpre[DriveW-1:0];
        out_data_q.move_done   <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_done_drives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.move_done |->
      (out_data_o.left_drive == '0) && (out_data_o.right_drive == '0))
    else $error("move_done with nonzero drive");

  a_start_sets_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.command == CMD_START) |=> moving_q)
    else $error("start transfer did not begin a move");

  a_cycle_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycle_q != '0)
    else $error("cycle count reached zero");

  a_result_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES) && out_valid_q && !out_ready_i |=> (state_q == ST_RES))
    else $error("result step overran a full output register");

  a_gain_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GAIN) && (k_q != K_LAST) |=> (state_q == ST_GAIN) && !in_ready_o)
    else $error("gain sequence cut short");
`endif

endmodule

// ===== bench/wheel_sync_pi_ramp_controller_test.sv =====
`timescale 1ns / 1ps

module wheel_sync_pi_ramp_controller_test;
  import wsp_pkg::*;

  // ramp and pi constants, speeds Q1.14
  localparam longint RampUp    = 164;
  localparam longint RampDown  = 328;
  localparam longint RampFloor = 2458;
  localparam longint DecelGain = 5000;
  localparam longint TermCap   = 1048576;
  localparam longint SumHi     = 64'sd2147483647;
  localparam longint SumLo     = -64'sd2147483648;
  localparam longint IntHi     = 64'sd140737488355327;
  localparam longint IntLo     = -64'sd140737488355328;
  localparam longint CycleTop  = 16777215;
  // kind three runs as a straight move
  localparam logic [1:0] KindReserved = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  wdata;
    wsp_in_t              item;
    logic                 typed;
    wsp_out_t             want;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  wsp_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  wsp_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  wheel_sync_pi_ramp_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // register copies
  logic [1:0]  cfg_kind   = 2'd0;
  logic [23:0] cfg_target = 24'd0;
  logic [31:0] cfg_kp     = 32'd429;
  logic [31:0] cfg_ki     = 32'd2147484;
  logic [14:0] cfg_start  = 15'd3277;
  logic [14:0] cfg_top    = 15'd13107;

  // move state
  longint wheel_r_sum   = 0;
  longint wheel_l_sum   = 0;
  longint sync_integral = 0;
  longint sample_count  = 1;
  longint ramp_level    = 3277;
  bit     in_motion     = 1'b0;

  wsp_out_t    drive_expect_q[$];
  script_row_t script_q[$];
  int          drive_mismatches = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  int          stim_count = 0;
  bit          idle_jitter = 1'b1;
  wsp_out_t    drive_head;

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // sign(err) * floor(|err| * gain / 2^18), magnitude capped
  function automatic longint pi_term(input longint err, input logic [31:0] gain);
    logic [127:0] mag;
    logic [127:0] scaled;
    longint       t;
    mag = (err < 0) ? -err : err;
    scaled = (mag * gain) >> 18;
    if (scaled > TermCap) scaled = TermCap;
    t = scaled[63:0];
    return (err < 0) ? -t : t;
  endfunction

  function automatic wsp_out_t predict_drive(input wsp_in_t item);
    wsp_out_t res;
    bit       spin;
    bit       fin;
    longint   dir, rd, ld, r, l, tgt, top, base, corr, left_cmd, right_cmd;
    spin = (cfg_kind == KIND_SPIN_POS) || (cfg_kind == KIND_SPIN_NEG);
    dir = (cfg_kind == KIND_SPIN_NEG) ? -1 : 1;
    rd = $signed(item.right_delta);
    ld = $signed(item.left_delta);
    tgt = cfg_target;
    top = cfg_top;
    base = cfg_start;
    fin = 1'b0;
    left_cmd = 0;
    right_cmd = 0;
    if (item.command == CMD_START) begin
      wheel_r_sum = 0;
      wheel_l_sum = 0;
      sync_integral = 0;
      sample_count = 1;
      ramp_level = base;
      in_motion = 1'b1;
      left_cmd = dir * ramp_level;
      right_cmd = spin ? -dir * ramp_level : ramp_level;
    end else if (!in_motion) begin
      fin = 1'b1;
    end else if (spin) begin
      r = -dir * rd;
      l = dir * ld;
      wheel_r_sum = sat(wheel_r_sum + r, SumLo, SumHi);
      wheel_l_sum = sat(wheel_l_sum + l, SumLo, SumHi);
      sync_integral = sat(sync_integral + (wheel_r_sum - wheel_l_sum), IntLo, IntHi);
      if (sample_count < CycleTop) sample_count++;
      if (wheel_r_sum > tgt || wheel_l_sum > tgt) begin
        in_motion = 1'b0;
        fin = 1'b1;
      end else begin
        corr = pi_term(sync_integral, cfg_ki) + pi_term(r - l, cfg_kp);
        left_cmd = dir * (ramp_level + corr);
        right_cmd = -dir * ramp_level;
      end
    end else begin
      wheel_r_sum = sat(wheel_r_sum + rd, SumLo, SumHi);
      wheel_l_sum = sat(wheel_l_sum + ld, SumLo, SumHi);
      sync_integral = sat(sample_count * rd - wheel_l_sum, IntLo, IntHi);
      if (sample_count < CycleTop) sample_count++;
      corr = pi_term(sync_integral, cfg_ki) + pi_term(rd - ld, cfg_kp);
      if (3 * wheel_l_sum <= tgt && ramp_level < top)
        ramp_level = sat(ramp_level + RampUp, 0, 32767);
      // slow down once the left wheel is within braking distance
      if (wheel_l_sum * 16384 > tgt * 16384 - (ramp_level - base) * DecelGain
          && ramp_level > RampFloor)
        ramp_level = ramp_level - RampDown;
      if (wheel_r_sum > tgt) begin
        in_motion = 1'b0;
        fin = 1'b1;
      end else begin
        left_cmd = ramp_level + corr;
        right_cmd = ramp_level;
      end
    end
    res.left_drive = 16'(sat(left_cmd, -32768, 32767));
    res.right_drive = 16'(sat(right_cmd, -32768, 32767));
    res.move_done = fin;
    return res;
  endfunction

  function automatic void add_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    script_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.wdata = val;
    script_q.push_back(row);
  endfunction

  function automatic void add_item(input logic cmd, input logic [15:0] rd, input logic [15:0] ld,
                                   input logic typed, input logic [15:0] wl,
                                   input logic [15:0] wr, input logic wd);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.command = cmd;
    row.item.right_delta = rd;
    row.item.left_delta = ld;
    row.typed = typed;
    row.want.left_drive = wl;
    row.want.right_drive = wr;
    row.want.move_done = wd;
    script_q.push_back(row);
  endfunction

  // encoder sample shaped for the current move kind, with some noise
  function automatic wsp_in_t wheel_sample();
    wsp_in_t it;
    int      mr, ml;
    it.command = CMD_SAMPLE;
    if ($urandom_range(99) < 8) begin
      it.right_delta = 16'($urandom);
      it.left_delta = 16'($urandom);
      return it;
    end
    mr = $urandom_range(0, 40);
    ml = mr + int'($urandom_range(0, 6)) - 3;
    if (cfg_kind == KIND_SPIN_POS) begin
      it.right_delta = 16'(-mr);
      it.left_delta = 16'(ml);
    end else if (cfg_kind == KIND_SPIN_NEG) begin
      it.right_delta = 16'(mr);
      it.left_delta = 16'(-ml);
    end else begin
      it.right_delta = 16'(mr);
      it.left_delta = 16'(ml);
    end
    return it;
  endfunction

  function automatic logic [31:0] pick_gain();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'd0;
    if (roll < 20) return 32'hFFFF_FFFF;
    if (roll < 60) return $urandom_range(0, 1 << 22);
    return $urandom;
  endfunction

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MOVE_KIND:   cfg_kind = val[1:0];
      REG_TARGET:      cfg_target = val[23:0];
      REG_PROP_GAIN:   cfg_kp = val;
      REG_INTEG_GAIN:  cfg_ki = val;
      REG_START_SPEED: cfg_start = val[14:0];
      REG_TOP_SPEED:   cfg_top = val[14:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input wsp_in_t item, input logic typed, input wsp_out_t want);
    wsp_out_t guess;
    while (idle_jitter && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    guess = predict_drive(item);
    drive_expect_q.push_back(typed ? want : guess);
  endtask

  task automatic offer(input wsp_in_t item);
    send_item(item, 1'b0, '0);
    stim_count++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // result check and receiver readiness
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (drive_expect_q.size() == 0) begin
        if (drive_mismatches < 10)
          $display("unexpected result: left %0d right %0d done %0b",
                   $signed(out_data_o.left_drive), $signed(out_data_o.right_drive),
                   out_data_o.move_done);
        drive_mismatches++;
      end else begin
        drive_head = drive_expect_q.pop_front();
        if (out_data_o.left_drive !== drive_head.left_drive
            || out_data_o.right_drive !== drive_head.right_drive
            || out_data_o.move_done !== drive_head.move_done) begin
          if (drive_mismatches < 10)
            $display("result %0d: want %0d %0d %0b, got %0d %0d %0b",
                     results_seen, $signed(drive_head.left_drive),
                     $signed(drive_head.right_drive), drive_head.move_done,
                     $signed(out_data_o.left_drive), $signed(out_data_o.right_drive),
                     out_data_o.move_done);
          drive_mismatches++;
        end
      end
      // long hold-off so the block backs up into its input
      if (results_seen == 600) hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idle_jitter && $urandom_range(99) < 7);
    end
  end

  initial begin
    #(64'd80_000_000);
    $display("wheel_sync_pi_ramp_controller verification failed");
    $finish;
  end

  initial begin
    wsp_in_t probe;
    int      phase;
    int      phase_base;
    int      steps;
    int      roll;

    // idle sample, start, target zero passed once the right count goes positive, then an idle sample
    add_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b1);
    add_item(CMD_START, 16'sd0, 16'sd0, 1'b1, 16'sd3277, 16'sd3277, 1'b0);
    add_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sd1, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b1);
    add_item(CMD_SAMPLE, -16'sd1, -16'sd1, 1'b1, 16'sd0, 16'sd0, 1'b1);
    // full gains, far target, extreme deltas
    add_write(REG_TARGET, 32'h00FF_FFFF);
    add_write(REG_PROP_GAIN, 32'hFFFF_FFFF);
    add_write(REG_INTEG_GAIN, 32'hFFFF_FFFF);
    add_item(CMD_START, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd3277, 16'sd3277, 1'b0);
    add_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sh8000, 16'sh8000, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0, 16'sd0, 1'b0);
    // zero speeds and gains
    add_write(REG_START_SPEED, 32'd0);
    add_write(REG_TOP_SPEED, 32'd0);
    add_write(REG_PROP_GAIN, 32'd0);
    add_write(REG_INTEG_GAIN, 32'd0);
    add_item(CMD_START, 16'sd9, 16'sd9, 1'b1, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sd5, 16'sd5, 1'b0, 16'sd0, 16'sd0, 1'b0);
    // spins at full base speed
    add_write(REG_MOVE_KIND, KIND_SPIN_POS);
    add_write(REG_START_SPEED, 32'd16384);
    add_write(REG_TOP_SPEED, 32'd16384);
    add_write(REG_INTEG_GAIN, 32'd2147484);
    add_write(REG_PROP_GAIN, 32'd429);
    add_item(CMD_START, 16'sd0, 16'sd0, 1'b1, 16'sd16384, -16'sd16384, 1'b0);
    add_item(CMD_SAMPLE, -16'sd100, 16'sd100, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_item(CMD_SAMPLE, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 16'sd0, 1'b0);
    add_write(REG_MOVE_KIND, KIND_SPIN_NEG);
    add_item(CMD_START, 16'sd0, 16'sd0, 1'b1, -16'sd16384, 16'sd16384, 1'b0);
    add_item(CMD_SAMPLE, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0, 1'b0);
    // ramp near its ceiling
    add_write(REG_MOVE_KIND, KindReserved);
    add_write(REG_START_SPEED, 32'd32700);
    add_write(REG_TOP_SPEED, 32'd32767);
    add_item(CMD_START, 16'sd0, 16'sd0, 1'b1, 16'sd32700, 16'sd32700, 1'b0);
    add_item(CMD_SAMPLE, 16'sd10, 16'sd10, 1'b0, 16'sd0, 16'sd0, 1'b0);
    // spin that ends on its first sample
    add_write(REG_TARGET, 32'd0);
    add_write(REG_MOVE_KIND, KIND_SPIN_POS);
    add_write(REG_START_SPEED, 32'd16384);
    add_item(CMD_START, 16'sd0, 16'sd0, 1'b1, 16'sd16384, -16'sd16384, 1'b0);
    add_item(CMD_SAMPLE, -16'sd1, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b1);
    add_item(CMD_SAMPLE, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b1);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < script_q.size(); i++) begin
      if (script_q[i].kind == ROW_WRITE) begin
        settle();
        set_reg(script_q[i].idx, script_q[i].wdata);
      end else begin
        send_item(script_q[i].item, script_q[i].typed, script_q[i].want);
      end
    end

    phase = 0;
    while (stim_count < 1600) begin
      settle();
      idle_jitter = (phase % 6) != 3;
      roll = $urandom_range(99);
      set_reg(REG_MOVE_KIND, roll < 40 ? KIND_STRAIGHT : roll < 65 ? KIND_SPIN_POS :
                             roll < 90 ? KIND_SPIN_NEG : KindReserved);
      roll = $urandom_range(99);
      set_reg(REG_TARGET, roll < 5 ? 32'd0 : roll < 10 ? 32'h00FF_FFFF :
                          $urandom_range(50, 4000));
      set_reg(REG_PROP_GAIN, pick_gain());
      set_reg(REG_INTEG_GAIN, pick_gain());
      roll = $urandom_range(99);
      set_reg(REG_START_SPEED, roll < 8 ? 32'd0 : roll < 14 ? $urandom :
                               $urandom_range(1000, 8000));
      roll = $urandom_range(99);
      set_reg(REG_TOP_SPEED, roll < 8 ? 32'd0 : roll < 14 ? 32'h7FFF :
                             $urandom_range(8000, 16384));
      // samples ahead of the start run on under the new settings
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 4)) offer(wheel_sample());
      phase_base = stim_count;
      while (stim_count - phase_base < 100) begin
        probe.command = CMD_START;
        probe.right_delta = 16'($urandom);
        probe.left_delta = 16'($urandom);
        offer(probe);
        steps = 0;
        while (in_motion && steps < 300 && $urandom_range(99) >= 2) begin
          offer(wheel_sample());
          steps++;
        end
        repeat ($urandom_range(0, 2)) offer(wheel_sample());
      end
      phase++;
    end

    // long straight run with opposing extreme deltas, the target never met
    settle();
    idle_jitter = 1'b0;
    set_reg(REG_MOVE_KIND, KIND_STRAIGHT);
    set_reg(REG_TARGET, 32'h00FF_FFFF);
    probe.command = CMD_START;
    probe.right_delta = 16'($urandom);
    probe.left_delta = 16'($urandom);
    offer(probe);
    probe.command = CMD_SAMPLE;
    probe.right_delta = 16'sh8000;
    probe.left_delta = 16'sh7FFF;
    repeat (200) offer(probe);

    settle();
    repeat (24) @(posedge clk_i);
    drive_mismatches += drive_expect_q.size();
    if (drive_mismatches == 0) begin
      $display("wheel_sync_pi_ramp_controller verification clean");
    end else begin
      $display("wheel_sync_pi_ramp_controller verification failed");
    end
    $finish;
  end

endmodule
